>>> design/complex_magnitude_statistics_macros.svh
// ----------------------------------------------------------------------------
// complex magnitude statistics assertion macros
// shared property forms, clocked on clk_i and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef COMPLEX_MAGNITUDE_STATISTICS_MACROS_SVH
`define COMPLEX_MAGNITUDE_STATISTICS_MACROS_SVH

// same-cycle implication
`define CMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// field widths, fixed-point settings and sequencer states
// ----------------------------------------------------------------------------
package cms_pkg;

  // sample and fraction format
  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 8;

  // result field widths
  localparam int unsigned CountW = 13;
  localparam int unsigned MeanW  = 24;
  localparam int unsigned RmsW   = 16;
  localparam int unsigned MaxW   = 16;
  localparam int unsigned StdW   = 24;
  localparam int unsigned PowerW = 44;

  // sequencer states, one-hot
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SQA      = 13'b0000000000010,
    S_SQB      = 13'b0000000000100,
    S_PSUM     = 13'b0000000001000,
    S_ROOT_MAG = 13'b0000000010000,
    S_ACC      = 13'b0000000100000,
    S_DIV_MEAN = 13'b0000001000000,
    S_DIV_PWR  = 13'b0000010000000,
    S_ROOT_RMS = 13'b0000100000000,
    S_PASS     = 13'b0001000000000,
    S_DIV_DEV  = 13'b0010000000000,
    S_ROOT_STD = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_e;

endpackage

>>> design/cms_if.sv
// ----------------------------------------------------------------------------
// cms channel interfaces
// sample input channel and statistics result channel, valid/ready
// ----------------------------------------------------------------------------
interface cms_in_if import cms_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_re;
  logic signed [SampleBits-1:0] sample_im;
  logic                         last_sample;

  modport source (output valid, sample_re, sample_im, last_sample, input ready);
  modport sink   (input valid, sample_re, sample_im, last_sample, output ready);
endinterface

interface cms_out_if import cms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] sample_count;
  logic [MeanW-1:0]  mean_mag_q8;
  logic [RmsW-1:0]   rms_mag;
  logic [MaxW-1:0]   max_mag;
  logic [StdW-1:0]   std_mag_q8;
  logic [PowerW-1:0] total_power;
  logic              truncated;

  modport source (output valid, sample_count, mean_mag_q8, rms_mag, max_mag, std_mag_q8,
                  total_power, truncated, input ready);
  modport sink   (input valid, sample_count, mean_mag_q8, rms_mag, max_mag, std_mag_q8,
                  total_power, truncated, output ready);
endinterface

>>> design/complex_magnitude_statistics.sv
// ----------------------------------------------------------------------------
// complex magnitude statistics
// magnitude, power, mean, maximum, rms and standard deviation over a set of samples
// ----------------------------------------------------------------------------
// One sample is taken at a time. Each sample goes through a shared squarer,
// then a bit-serial square root giving one result bit per cycle, so a sample
// occupies the block through the squaring, the root and the accumulate step
// before the next is taken. A sample marked last then starts the report: three
// restoring divisions, two more square roots, and one pass over the stored
// magnitudes at one store read per cycle. The result sits in an output
// register, so new samples are taken while it waits. Samples beyond MAX_SAMPLES
// are dropped and reported through the truncated flag.
`include "complex_magnitude_statistics_macros.svh"

module complex_magnitude_statistics import cms_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic clk_i,
  input  logic rst_ni,
  cms_in_if.sink    in_i,
  cms_out_if.source out_o
);

  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned PW   = 2 * SampleBits;
  localparam int unsigned MAGW = SampleBits;
  localparam int unsigned MSW  = MAGW + CW;
  localparam int unsigned PSW  = PW + CW;
  localparam int unsigned MQW  = MAGW + FracBits;
  localparam int unsigned DSW  = 2 * MQW + CW;
  localparam int unsigned RW   = DSW + (DSW % 2);
  localparam int unsigned HW   = RW / 2;
  localparam int unsigned IW   = $clog2(DSW + 1);

  state_e state_q;

  // sample registers
  logic [SampleBits-1:0] a_q, b_q;
  logic                  last_q;

  // statistics
  logic [CW-1:0]   count_q;
  logic [MSW-1:0]  mag_sum_q;
  logic [PSW-1:0]  power_sum_q;
  logic [MAGW-1:0] max_q;
  logic            ovf_q;
  logic [DSW-1:0]  dev_sum_q;
  logic [MQW-1:0]  mean_q;
  logic [HW-1:0]   rms_q;

  // shared units
  logic [2*MQW-1:0] mul_q;
  logic [RW-1:0]    rad_q;
  logic [HW+1:0]    srem_q;
  logic [HW-1:0]    root_q;
  logic [DSW-1:0]   num_q;
  logic [CW-1:0]    drem_q;
  logic [IW-1:0]    iter_q;

  // second pass
  logic [CW-1:0]   idx_q;
  logic            v1_q, v2_q;
  logic [MAGW-1:0] rd_q;
  logic [MAGW-1:0] mem_q [MAX_SAMPLES];

  // output register
  logic              ov_q;
  logic [CountW-1:0] o_cnt_q;
  logic [MeanW-1:0]  o_mean_q;
  logic [RmsW-1:0]   o_rms_q;
  logic [MaxW-1:0]   o_max_q;
  logic [StdW-1:0]   o_std_q;
  logic [PowerW-1:0] o_pwr_q;
  logic              o_trunc_q;

  logic [SampleBits-1:0] abs_re, abs_im;
  logic [MQW-1:0]        mul_op;
  logic [HW+1:0]         rem_sh, trial, srem_step;
  logic                  root_ge;
  logic [HW-1:0]         root_step;
  logic [CW:0]           drem_sh;
  logic                  div_ge;
  logic [CW-1:0]         drem_step;
  logic [DSW-1:0]        num_step;
  logic [MQW-1:0]        scaled, dev;
  logic [PW:0]           psum;
  logic                  iter_last, in_xfer, issue;

  // magnitude of the incoming parts
  assign abs_re = in_i.sample_re[SampleBits-1] ? (~in_i.sample_re + 1'b1) : in_i.sample_re;
  assign abs_im = in_i.sample_im[SampleBits-1] ? (~in_i.sample_im + 1'b1) : in_i.sample_im;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign iter_last  = (iter_q == IW'(1));

  // square root step, one result bit
  assign rem_sh    = {srem_q[HW-1:0], rad_q[RW-1:RW-2]};
  assign trial     = {root_q, 2'b01};
  assign root_ge   = (rem_sh >= trial);
  assign srem_step = root_ge ? (rem_sh - trial) : rem_sh;
  assign root_step = {root_q[HW-2:0], root_ge};

  // restoring division step, one quotient bit
  assign drem_sh   = {drem_q, num_q[DSW-1]};
  assign div_ge    = (drem_sh >= {1'b0, count_q});
  assign drem_step = div_ge ? CW'(drem_sh - {1'b0, count_q}) : CW'(drem_sh);
  assign num_step  = {num_q[DSW-2:0], div_ge};

  // deviation of a stored magnitude from the mean
  assign scaled = MQW'(rd_q) << FracBits;
  assign dev    = (scaled >= mean_q) ? (scaled - mean_q) : (mean_q - scaled);

  // shared multiplier operand
  always_comb begin
    unique case (state_q)
      S_SQA:   mul_op = MQW'(a_q);
      S_SQB:   mul_op = MQW'(b_q);
      default: mul_op = dev;
    endcase
  end

  assign psum  = (PW + 1)'(rad_q) + (PW + 1)'(mul_q);
  assign issue = (idx_q < count_q);

  // magnitude store
  always_ff @(posedge clk_i) begin
    if (state_q == S_ACC) begin
      mem_q[count_q[AW-1:0]] <= root_q[MAGW-1:0];
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_op * mul_op;
    unique case (state_q)
      S_IDLE: begin
        a_q    <= abs_re;
        b_q    <= abs_im;
        last_q <= in_i.last_sample;
        num_q  <= DSW'(mag_sum_q) << FracBits;
        drem_q <= '0;
        iter_q <= IW'(DSW);
      end
      S_SQB: rad_q <= RW'(mul_q);
      S_PSUM: begin
        rad_q  <= RW'(psum);
        srem_q <= '0;
        root_q <= '0;
        iter_q <= IW'(HW);
      end
      S_ROOT_MAG, S_ROOT_RMS, S_ROOT_STD: begin
        rad_q  <= rad_q << 2;
        srem_q <= srem_step;
        root_q <= root_step;
        iter_q <= iter_q - 1'b1;
        if (state_q == S_ROOT_RMS && iter_last) begin
          rms_q <= root_step;
        end
      end
      S_ACC: begin
        num_q  <= DSW'(mag_sum_q + MSW'(root_q[MAGW-1:0])) << FracBits;
        drem_q <= '0;
        iter_q <= IW'(DSW);
      end
      S_DIV_MEAN, S_DIV_PWR, S_DIV_DEV: begin
        num_q  <= num_step;
        drem_q <= drem_step;
        iter_q <= iter_q - 1'b1;
        if (iter_last) begin
          drem_q <= '0;
          iter_q <= (state_q == S_DIV_MEAN) ? IW'(DSW) : IW'(HW);
          rad_q  <= RW'(num_step);
          srem_q <= '0;
          root_q <= '0;
          if (state_q == S_DIV_MEAN) begin
            mean_q <= MQW'(num_step);
            num_q  <= DSW'(power_sum_q);
          end
        end
      end
      S_PASS: begin
        if (!issue && !v1_q && !v2_q) begin
          num_q  <= dev_sum_q;
          drem_q <= '0;
          iter_q <= IW'(DSW);
        end
      end
      default: ;
    endcase
  end

  // sequencer and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mag_sum_q   <= '0;
      power_sum_q <= '0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
      dev_sum_q   <= '0;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (count_q < CW'(MAX_SAMPLES)) begin
              state_q <= S_SQA;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= in_i.last_sample ? S_DIV_MEAN : S_IDLE;
            end
          end
        end
        S_SQA:  state_q <= S_SQB;
        S_SQB:  state_q <= S_PSUM;
        S_PSUM: begin
          power_sum_q <= power_sum_q + PSW'(psum);
          state_q     <= S_ROOT_MAG;
        end
        S_ROOT_MAG: if (iter_last) state_q <= S_ACC;
        S_ACC: begin
          count_q   <= count_q + 1'b1;
          mag_sum_q <= mag_sum_q + MSW'(root_q[MAGW-1:0]);
          if (root_q[MAGW-1:0] > max_q) begin
            max_q <= root_q[MAGW-1:0];
          end
          state_q <= last_q ? S_DIV_MEAN : S_IDLE;
        end
        S_DIV_MEAN: if (iter_last) state_q <= S_DIV_PWR;
        S_DIV_PWR:  if (iter_last) state_q <= S_ROOT_RMS;
        S_ROOT_RMS: begin
          if (iter_last) begin
            idx_q     <= '0;
            v1_q      <= 1'b0;
            v2_q      <= 1'b0;
            dev_sum_q <= '0;
            state_q   <= S_PASS;
          end
        end
        S_PASS: begin
          // read, square, accumulate
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          v1_q <= issue;
          v2_q <= v1_q;
          if (v2_q) begin
            dev_sum_q <= dev_sum_q + DSW'(mul_q);
          end
          if (!issue && !v1_q && !v2_q) begin
            state_q <= S_DIV_DEV;
          end
        end
        S_DIV_DEV:  if (iter_last) state_q <= S_ROOT_STD;
        S_ROOT_STD: if (iter_last) state_q <= S_EMIT;
        S_EMIT: begin
          if (!ov_q || out_o.ready) begin
            ov_q        <= 1'b1;
            count_q     <= '0;
            mag_sum_q   <= '0;
            power_sum_q <= '0;
            max_q       <= '0;
            ovf_q       <= 1'b0;
            dev_sum_q   <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result register load
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!ov_q || out_o.ready)) begin
      o_cnt_q   <= CountW'(count_q);
      o_mean_q  <= MeanW'(mean_q);
      o_rms_q   <= RmsW'(rms_q);
      o_max_q   <= MaxW'(max_q);
      o_std_q   <= StdW'(root_q);
      o_pwr_q   <= PowerW'(power_sum_q);
      o_trunc_q <= ovf_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.sample_count = o_cnt_q;
  assign out_o.mean_mag_q8  = o_mean_q;
  assign out_o.rms_mag      = o_rms_q;
  assign out_o.max_mag      = o_max_q;
  assign out_o.std_mag_q8   = o_std_q;
  assign out_o.total_power  = o_pwr_q;
  assign out_o.truncated    = o_trunc_q;

  // checks
  `CMS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_SAMPLES), "count beyond store depth")
  `CMS_ASSERT_IMP(a_report_nonempty, state_q == S_EMIT, count_q != '0, "report with no samples")
  `CMS_ASSERT_IMP(a_mean_le_max, state_q == S_PASS, mean_q <= (MQW'(max_q) << FracBits), "mean above maximum")
  `CMS_ASSERT_IMP(a_pass_index, state_q == S_PASS, idx_q <= count_q, "pass index past count")
  `CMS_ASSERT_NXT(a_emit_valid, state_q == S_EMIT && (!ov_q || out_o.ready), ov_q && state_q == S_IDLE, "result not loaded")

endmodule
